// ===== rtl/baoab_pkg.sv =====
// ----------------------------------------------------------------------------
// baoab_pkg
// Shared types, constants, microcode program and helpers for the BAOAB
// oscillator step core.
// ----------------------------------------------------------------------------
package baoab_pkg;

    localparam int STATE_W    = 32;
    localparam int COEF_W     = 32;
    localparam int PHASE_W    = 32;
    localparam int MUL_A_W    = 34;
    localparam int PROD_W     = 66;
    localparam int Q_FRAC     = 30;
    localparam int RND_W      = PROD_W - Q_FRAC;
    localparam int EXT_W      = RND_W + 1;
    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam int SINE_ROM_W = SINE_IDX_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int PC_W       = 4;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KICK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOST      = 3'd5;

    localparam logic [1:0] SEL_A_X  = 2'd0;
    localparam logic [1:0] SEL_A_U  = 2'd1;
    localparam logic [1:0] SEL_A_SN = 2'd2;
    localparam logic [1:0] SEL_A_NQ = 2'd3;

    localparam logic [1:0] SEL_B_K = 2'd0;
    localparam logic [1:0] SEL_B_D = 2'd1;
    localparam logic [1:0] SEL_B_G = 2'd2;
    localparam logic [1:0] SEL_B_S = 2'd3;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    localparam logic [1:0] U_HOLD = 2'd0;
    localparam logic [1:0] U_SUB  = 2'd1;
    localparam logic [1:0] U_LOAD = 2'd2;

    localparam logic [1:0] X_HOLD    = 2'd0;
    localparam logic [1:0] X_ADD_U   = 2'd1;
    localparam logic [1:0] X_ADD_ACC = 2'd2;

    localparam logic [1:0] JMP_NEXT     = 2'd0;
    localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
    localparam logic [1:0] JMP_WAIT_OUT = 2'd2;

    localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] STEP_FIRST = 4'd1;
    localparam logic [PC_W-1:0] STEP_LAST  = 4'd12;

    typedef logic signed [STATE_W-1:0] t_state;
    typedef logic signed [EXT_W-1:0]   t_ext;
    typedef t_state                    t_sine_rom [0:SINE_DEPTH];

    typedef struct packed {
        logic       mul_en;
        logic [1:0] sel_a;
        logic [1:0] sel_b;
        logic [1:0] acc_op;
        logic [1:0] u_op;
        logic [1:0] x_op;
        logic [1:0] jmp;
    } t_uword;

    function automatic t_uword uw(input logic m, input logic [1:0] a, input logic [1:0] b,
                                  input logic [1:0] acc, input logic [1:0] u,
                                  input logic [1:0] x, input logic [1:0] j);
        t_uword w;
        w.mul_en = m;
        w.sel_a  = a;
        w.sel_b  = b;
        w.acc_op = acc;
        w.u_op   = u;
        w.x_op   = x;
        w.jmp    = j;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_HOLD, U_HOLD, X_HOLD,    JMP_WAIT_IN);
            4'd1:    w = uw(1'b1, SEL_A_X,  SEL_B_K, ACC_HOLD, U_HOLD, X_HOLD,    JMP_NEXT);
            4'd2:    w = uw(1'b1, SEL_A_SN, SEL_B_D, ACC_LOAD, U_HOLD, X_HOLD,    JMP_NEXT);
            4'd3:    w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_ADD,  U_HOLD, X_HOLD,    JMP_NEXT);
            4'd4:    w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_HOLD, U_SUB,  X_HOLD,    JMP_NEXT);
            4'd5:    w = uw(1'b1, SEL_A_U,  SEL_B_G, ACC_HOLD, U_HOLD, X_ADD_U,   JMP_NEXT);
            4'd6:    w = uw(1'b1, SEL_A_NQ, SEL_B_S, ACC_LOAD, U_HOLD, X_HOLD,    JMP_NEXT);
            4'd7:    w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_ADD,  U_HOLD, X_HOLD,    JMP_NEXT);
            4'd8:    w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_HOLD, U_LOAD, X_ADD_ACC, JMP_NEXT);
            4'd9:    w = uw(1'b1, SEL_A_X,  SEL_B_K, ACC_HOLD, U_HOLD, X_HOLD,    JMP_NEXT);
            4'd10:   w = uw(1'b1, SEL_A_SN, SEL_B_D, ACC_LOAD, U_HOLD, X_HOLD,    JMP_NEXT);
            4'd11:   w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_ADD,  U_HOLD, X_HOLD,    JMP_NEXT);
            4'd12:   w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_HOLD, U_SUB,  X_HOLD,    JMP_WAIT_OUT);
            default: w = uw(1'b0, SEL_A_X,  SEL_B_K, ACC_HOLD, U_HOLD, X_HOLD,    JMP_WAIT_OUT);
        endcase
        return w;
    endfunction

    function automatic t_ext sx(input t_state v);
        return {{(EXT_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    function automatic t_state sat_state(input t_ext v);
        t_state r;
        if (v[EXT_W-1:STATE_W-1] == {(EXT_W-STATE_W+1){1'b0}} ||
            v[EXT_W-1:STATE_W-1] == {(EXT_W-STATE_W+1){1'b1}}) begin
            r = v[STATE_W-1:0];
        end else if (v[EXT_W-1]) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic longint cube_q30(input longint t, input longint x);
        return ((t * x) >>> Q_FRAC) * x >>> Q_FRAC;
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom rom;
        longint x;
        longint term;
        longint sum;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
            sum  = x;
            term = -cube_q30(x, x) / 64'sd6;
            sum  = sum + term;
            term = -cube_q30(term, x) / 64'sd20;
            sum  = sum + term;
            term = -cube_q30(term, x) / 64'sd42;
            sum  = sum + term;
            term = -cube_q30(term, x) / 64'sd72;
            sum  = sum + term;
            term = -cube_q30(term, x) / 64'sd110;
            sum  = sum + term;
            term = -cube_q30(term, x) / 64'sd156;
            sum  = sum + term;
            term = -cube_q30(term, x) / 64'sd210;
            sum  = sum + term;
            if (sum > ONE_Q30) begin
                sum = ONE_Q30;
            end
            if (sum < 0) begin
                sum = 0;
            end
            rom[k] = STATE_W'(sum);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/baoab_langevin_oscillator_step_core.sv =====
// ----------------------------------------------------------------------------
// baoab_langevin_oscillator_step_core
// One BAOAB Langevin step of a damped, sine-driven harmonic oscillator per
// noise item, run by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// Each accepted noise item runs through one idle step that takes the item
// and twelve program steps that issue six products through the single
// 34x32 multiplier and its rounding and saturation stage. The result register
// lets the next item enter while a finished result waits; the last step holds
// only when that register is still full and stalled. Configuration writes
// are always taken (ready is tied high) and must arrive while idle.
module baoab_langevin_oscillator_step_core
    import baoab_pkg::*;
#(
    parameter int NOISE_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [NOISE_WIDTH-1:0] i_noise_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic        [PHASE_W-1:0]    o_step_index,
    output logic signed [STATE_W-1:0]    o_position_out,
    output logic signed [STATE_W-1:0]    o_velocity_out,
    output logic                         o_lost_flag,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [COEF_W-1:0]     i_cfg_data
);

    localparam int        NQ_PAD   = MUL_A_W - NOISE_WIDTH;
    localparam t_sine_rom SINE_ROM = build_sine();
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (Q_FRAC - 1);

    t_state                        r_stiffness;
    t_state                        r_drive;
    logic         [PHASE_W-1:0]    r_phase_inc;
    t_state                        r_damping;
    t_state                        r_kick;
    t_state                        r_lost_limit;

    logic         [PC_W-1:0]       r_pc;
    logic         [PC_W-1:0]       n_pc;
    t_state                        r_x;
    t_state                        n_x;
    t_state                        r_u;
    t_state                        n_u;
    t_state                        r_acc;
    t_state                        n_acc;
    logic         [PHASE_W-1:0]    r_phase;
    logic         [PHASE_W-1:0]    r_step_count;
    logic signed [NOISE_WIDTH-1:0] r_noise;
    logic signed [PROD_W-1:0]      r_prod;
    t_state                        r_sine_mag;
    logic                          r_sine_neg;

    logic                          r_out_valid;
    logic         [PHASE_W-1:0]    r_out_step;
    t_state                        r_out_pos;
    t_state                        r_out_vel;
    logic                          r_out_lost;

    t_uword                        w_uw;
    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_go;
    logic                          w_finish;
    logic         [SINE_IDX_W-1:0] w_sine_raw;
    logic         [SINE_ROM_W-1:0] w_sine_idx;
    t_state                        w_sn;
    logic signed [MUL_A_W-1:0]     w_mul_a;
    t_state                        w_mul_b;
    logic signed [PROD_W-1:0]      w_rnd_sum;
    t_state                        w_psat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness  <= '0;
            r_drive      <= '0;
            r_phase_inc  <= '0;
            r_damping    <= 32'sh4000_0000;
            r_kick       <= '0;
            r_lost_limit <= 32'sh7fff_ffff;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_STIFFNESS: r_stiffness  <= i_cfg_data;
                REG_DRIVE:     r_drive      <= i_cfg_data;
                REG_PHASE_INC: r_phase_inc  <= i_cfg_data;
                REG_DAMPING:   r_damping    <= i_cfg_data;
                REG_KICK:      r_kick       <= i_cfg_data;
                REG_LOST:      r_lost_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_uw       = ucode(r_pc);
    assign o_in_stall = (r_pc != STEP_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !(r_out_valid && i_out_stall);
    assign w_go       = (w_uw.jmp == JMP_NEXT) || ((w_uw.jmp == JMP_WAIT_OUT) && w_out_free);
    assign w_finish   = (w_uw.jmp == JMP_WAIT_OUT) && w_out_free;

    always_comb begin
        unique case (w_uw.jmp)
            JMP_WAIT_IN:  n_pc = w_in_acc ? STEP_FIRST : STEP_IDLE;
            JMP_NEXT:     n_pc = r_pc + PC_W'(1);
            JMP_WAIT_OUT: n_pc = w_out_free ? STEP_IDLE : r_pc;
            default:      n_pc = STEP_IDLE;
        endcase
    end

    assign w_sine_raw = r_phase[PHASE_W-3 -: SINE_IDX_W];
    assign w_sine_idx = r_phase[PHASE_W-2] ? (SINE_ROM_W'(SINE_DEPTH) - {1'b0, w_sine_raw})
                                           : {1'b0, w_sine_raw};

    always_ff @(posedge i_clk) begin
        r_sine_mag <= SINE_ROM[w_sine_idx];
        r_sine_neg <= r_phase[PHASE_W-1];
    end

    assign w_sn = r_sine_neg ? -r_sine_mag : r_sine_mag;

    always_comb begin
        case (w_uw.sel_a)
            SEL_A_X:  w_mul_a = MUL_A_W'(r_x);
            SEL_A_U:  w_mul_a = MUL_A_W'(r_u);
            SEL_A_SN: w_mul_a = MUL_A_W'(w_sn);
            default:  w_mul_a = {r_noise, {NQ_PAD{1'b0}}};
        endcase
        case (w_uw.sel_b)
            SEL_B_K: w_mul_b = r_stiffness;
            SEL_B_D: w_mul_b = r_drive;
            SEL_B_G: w_mul_b = r_damping;
            default: w_mul_b = r_kick;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_uw.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (w_in_acc) begin
            r_noise <= i_noise_sample;
        end
    end

    assign w_rnd_sum = r_prod + ROUND_BIAS;
    assign w_psat    = sat_state({w_rnd_sum[PROD_W-1], w_rnd_sum[PROD_W-1:Q_FRAC]});

    always_comb begin
        case (w_uw.acc_op)
            ACC_LOAD: n_acc = w_psat;
            ACC_ADD:  n_acc = sat_state(sx(r_acc) + sx(w_psat));
            default:  n_acc = r_acc;
        endcase
        case (w_uw.u_op)
            U_SUB:   n_u = sat_state(sx(r_u) - sx(r_acc));
            U_LOAD:  n_u = r_acc;
            default: n_u = r_u;
        endcase
        case (w_uw.x_op)
            X_ADD_U:   n_x = sat_state(sx(r_x) + sx(r_u));
            X_ADD_ACC: n_x = sat_state(sx(r_x) + sx(r_acc));
            default:   n_x = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= STEP_IDLE;
            r_x          <= '0;
            r_u          <= '0;
            r_phase      <= '0;
            r_step_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_go) begin
                r_x <= n_x;
                r_u <= n_u;
            end
            if (w_finish) begin
                r_phase      <= r_phase + r_phase_inc;
                r_step_count <= r_step_count + PHASE_W'(1);
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_step <= r_step_count;
            r_out_pos  <= r_x;
            r_out_vel  <= n_u;
            r_out_lost <= (r_x > r_lost_limit);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_step_index   = r_out_step;
    assign o_position_out = r_out_pos;
    assign o_velocity_out = r_out_vel;
    assign o_lost_flag    = r_out_lost;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_pc == STEP_FIRST))
        else $error("accepted item did not start the program");

    a_finish_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_step_count == $past(r_step_count) + PHASE_W'(1)) && r_out_valid)
        else $error("finished step did not advance the count or post a result");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc != STEP_IDLE) |=> ((r_pc == STEP_IDLE) || o_in_stall) &&
            ((r_pc == STEP_IDLE) || ($past(r_pc) != STEP_IDLE) || $past(w_in_acc)))
        else $error("sequencer left idle without an accepted item");

endmodule
